// ===== rtl/cpr_pkg.sv =====
// ----------------------------------------------------------------------------
// cpr_pkg
// Types and constants shared by the clock page replacement block.
// ----------------------------------------------------------------------------
package cpr_pkg;

  localparam int PAGE_W   = 20;
  localparam int SLOT_W   = 6;
  localparam int FAULT_W  = 32;

  localparam logic [FAULT_W-1:0] FAULT_MAX = '1;

  typedef struct packed {
    logic              refd;
    logic [PAGE_W-1:0] page;
  } frame_word_t;

  typedef struct packed {
    logic               hit;
    logic [SLOT_W-1:0]  frame_index;
    logic               evicted_valid;
    logic [PAGE_W-1:0]  evicted_page;
    logic [FAULT_W-1:0] fault_total;
  } result_t;

  localparam int RESULT_W = $bits(result_t);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HSCAN,
    ST_SWEEP,
    ST_FILL,
    ST_DONE
  } state_t;

endpackage

// ===== rtl/clock_page_replacement.sv =====
// ----------------------------------------------------------------------------
// clock_page_replacement
// Second-chance page replacement over a ring of FRAMES frames.
// ----------------------------------------------------------------------------
// Page references enter through a queue: a word is taken when push is high
// and full is low. Results leave through a queue: the oldest result word sits
// on the result ports while empty is low and is taken when pop is high.
// A small input queue feeds the replacement engine, and a small output queue
// holds finished results, so either side may stall without losing a word.
// The engine handles one reference at a time and scans its frame memory one
// frame a cycle through a single read port. A hit ends the scan at the
// matching frame; a miss with a free frame scans the filled frames, or none
// when none is filled, and fills the next free frame; a miss on a full ring
// sweeps from the hand, clearing each set reference bit, until it finds a
// frame whose bit is clear. The engine takes the next reference only after
// it hands a result on.
// At reset all frames are free, the hand sits at frame zero, the fault total
// is zero and both queues are emptied.
// When the receiver stops popping, the output queue fills, the engine waits
// with its result and the input queue then raises full.
// ----------------------------------------------------------------------------
module clock_page_replacement #(
  parameter int FRAMES = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  logic [cpr_pkg::PAGE_W-1:0]  page_number,
  output logic                        empty,
  input  logic                        pop,
  output logic                        hit,
  output logic [cpr_pkg::SLOT_W-1:0]  frame_index,
  output logic                        evicted_valid,
  output logic [cpr_pkg::PAGE_W-1:0]  evicted_page,
  output logic [cpr_pkg::FAULT_W-1:0] fault_total
);

  logic                       in_empty;
  logic                       in_pop;
  logic [cpr_pkg::PAGE_W-1:0] in_page;
  logic                       out_full;
  logic                       out_push;
  cpr_pkg::result_t           eng_result;
  cpr_pkg::result_t           out_result;

  cpr_queue #(
    .WIDTH (cpr_pkg::PAGE_W),
    .DEPTH (2)
  ) u_in_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .full  (full),
    .wdata (page_number),
    .pop   (in_pop),
    .empty (in_empty),
    .rdata (in_page)
  );

  cpr_engine #(
    .FRAMES (FRAMES)
  ) u_engine (
    .clk        (clk),
    .rst        (rst),
    .in_empty   (in_empty),
    .in_page    (in_page),
    .in_pop     (in_pop),
    .out_full   (out_full),
    .out_push   (out_push),
    .out_result (eng_result)
  );

  cpr_queue #(
    .WIDTH (cpr_pkg::RESULT_W),
    .DEPTH (2)
  ) u_out_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (out_push),
    .full  (out_full),
    .wdata (eng_result),
    .pop   (pop),
    .empty (empty),
    .rdata (out_result)
  );

  assign hit           = out_result.hit;
  assign frame_index   = out_result.frame_index;
  assign evicted_valid = out_result.evicted_valid;
  assign evicted_page  = out_result.evicted_page;
  assign fault_total   = out_result.fault_total;

endmodule

// ===== rtl/cpr_queue.sv =====
// ----------------------------------------------------------------------------
// cpr_queue
// Small first-in first-out buffer of registers with push/full and pop/empty.
// ----------------------------------------------------------------------------
module cpr_queue #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] rdata
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots[rptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= ptr_inc(wptr);
      end
      if (do_pop) begin
        rptr <= ptr_inc(rptr);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ===== rtl/cpr_engine.sv =====
// ----------------------------------------------------------------------------
// cpr_engine
// Frame table and clock hand: scans for a hit, fills a free frame or sweeps
// the ring for a victim, and builds one result word per reference.
// ----------------------------------------------------------------------------
module cpr_engine #(
  parameter int FRAMES = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_empty,
  input  logic [cpr_pkg::PAGE_W-1:0]  in_page,
  output logic                        in_pop,
  input  logic                        out_full,
  output logic                        out_push,
  output cpr_pkg::result_t            out_result
);

  localparam int IDX_W = $clog2(FRAMES);
  localparam int CNT_W = $clog2(FRAMES + 1);

  cpr_pkg::frame_word_t mem [FRAMES];

  cpr_pkg::state_t             state;
  cpr_pkg::state_t             state_next;
  logic [CNT_W-1:0]            fill;
  logic [IDX_W-1:0]            hand;
  logic [cpr_pkg::FAULT_W-1:0] fault;
  logic [cpr_pkg::PAGE_W-1:0]  page_q;
  logic [IDX_W-1:0]            ra;
  logic                        issue_done;
  logic                        rd_v;
  logic [IDX_W-1:0]            rd_idx;
  cpr_pkg::frame_word_t        rd_word;
  cpr_pkg::result_t            res;

  logic                        issue_en;
  logic                        stop;
  logic                        rd_match;
  logic                        rd_last;
  logic                        we;
  logic [IDX_W-1:0]            wa;
  cpr_pkg::frame_word_t        wd;
  logic [cpr_pkg::FAULT_W-1:0] fault_inc;
  logic                        ring_full;

  function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i);
    idx_inc = (i == IDX_W'(FRAMES - 1)) ? '0 : i + IDX_W'(1);
  endfunction

  assign rd_match   = rd_v && (rd_word.page == page_q);
  assign rd_last    = (CNT_W'(rd_idx) + CNT_W'(1)) == fill;
  assign ring_full  = (fill == CNT_W'(FRAMES));
  assign fault_inc  = (fault == cpr_pkg::FAULT_MAX) ? fault : fault + cpr_pkg::FAULT_W'(1);
  assign issue_en   = ((state == cpr_pkg::ST_HSCAN) && !issue_done) ||
                      (state == cpr_pkg::ST_SWEEP);
  assign out_result = res;

  always_comb begin
    state_next = state;
    unique case (state)
      cpr_pkg::ST_IDLE: begin
        if (!in_empty) begin
          state_next = (fill == '0) ? cpr_pkg::ST_FILL : cpr_pkg::ST_HSCAN;
        end
      end
      cpr_pkg::ST_HSCAN: begin
        if (rd_match) begin
          state_next = cpr_pkg::ST_DONE;
        end else if (rd_v && rd_last) begin
          state_next = ring_full ? cpr_pkg::ST_SWEEP : cpr_pkg::ST_FILL;
        end
      end
      cpr_pkg::ST_SWEEP: begin
        if (rd_v && !rd_word.refd) begin
          state_next = cpr_pkg::ST_DONE;
        end
      end
      cpr_pkg::ST_FILL: begin
        state_next = cpr_pkg::ST_DONE;
      end
      cpr_pkg::ST_DONE: begin
        if (!out_full) begin
          state_next = cpr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = cpr_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_pop   = 1'b0;
    out_push = 1'b0;
    stop     = 1'b0;
    we       = 1'b0;
    wa       = rd_idx;
    wd       = rd_word;
    unique case (state)
      cpr_pkg::ST_IDLE: begin
        in_pop = !in_empty;
      end
      cpr_pkg::ST_HSCAN: begin
        if (rd_match) begin
          we   = 1'b1;
          wd   = '{refd: 1'b1, page: page_q};
          stop = 1'b1;
        end else if (rd_v && rd_last) begin
          stop = 1'b1;
        end
      end
      cpr_pkg::ST_SWEEP: begin
        if (rd_v) begin
          we = 1'b1;
          if (rd_word.refd) begin
            wd = '{refd: 1'b0, page: rd_word.page};
          end else begin
            wd   = '{refd: 1'b1, page: page_q};
            stop = 1'b1;
          end
        end
      end
      cpr_pkg::ST_FILL: begin
        we = 1'b1;
        wa = fill[IDX_W-1:0];
        wd = '{refd: 1'b1, page: page_q};
      end
      cpr_pkg::ST_DONE: begin
        out_push = !out_full;
      end
      default: begin
        in_pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (issue_en) begin
      rd_word <= mem[ra];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= cpr_pkg::ST_IDLE;
      fill       <= '0;
      hand       <= '0;
      fault      <= '0;
      rd_v       <= 1'b0;
      issue_done <= 1'b0;
    end else begin
      state <= state_next;
      rd_v  <= issue_en && !stop;
      if (issue_en) begin
        ra <= idx_inc(ra);
        if ((CNT_W'(ra) + CNT_W'(1)) == fill) begin
          issue_done <= 1'b1;
        end
      end
      rd_idx <= ra;
      unique case (state)
        cpr_pkg::ST_IDLE: begin
          if (!in_empty) begin
            page_q     <= in_page;
            ra         <= '0;
            issue_done <= 1'b0;
          end
        end
        cpr_pkg::ST_HSCAN: begin
          if (rd_match) begin
            res <= '{hit: 1'b1, frame_index: cpr_pkg::SLOT_W'(rd_idx),
                     evicted_valid: 1'b0, evicted_page: '0, fault_total: fault};
          end else if (rd_v && rd_last) begin
            ra <= hand;
          end
        end
        cpr_pkg::ST_SWEEP: begin
          if (rd_v && !rd_word.refd) begin
            res   <= '{hit: 1'b0, frame_index: cpr_pkg::SLOT_W'(rd_idx),
                       evicted_valid: 1'b1, evicted_page: rd_word.page,
                       fault_total: fault_inc};
            fault <= fault_inc;
            hand  <= idx_inc(rd_idx);
          end
        end
        cpr_pkg::ST_FILL: begin
          res   <= '{hit: 1'b0, frame_index: cpr_pkg::SLOT_W'(fill[IDX_W-1:0]),
                     evicted_valid: 1'b0, evicted_page: '0, fault_total: fault_inc};
          fault <= fault_inc;
          fill  <= fill + CNT_W'(1);
        end
        cpr_pkg::ST_DONE: begin
          issue_done <= 1'b0;
        end
        default: begin
          issue_done <= 1'b0;
        end
      endcase
    end
  end

endmodule
